FILE: src/rlcr_pkg.sv
// ----------------------------------------------------------------------------
// rlcr_pkg
// Types, widths and constants shared by the rope link relaxer files.
// ----------------------------------------------------------------------------
package rlcr_pkg;

  localparam int COORD_W  = 24;
  localparam int LEN_W    = 16;
  localparam int STIFF_W  = 9;
  localparam int IDX_W    = 4;
  localparam int MAX_EMIT = 16;
  localparam int MAG_W    = 25;               // |coordinate difference|
  localparam int SQ_W     = 52;               // sum of three squares
  localparam int DIST_W   = 26;               // root of SQ_W
  localparam int DIFF_W   = DIST_W + 1;
  localparam int PROD_W   = DIST_W + MAG_W;
  localparam int SCL_W    = PROD_W + STIFF_W;
  localparam int NUM_W    = 62;
  localparam int DEN_W    = DIST_W + 8;
  localparam int SUM_W    = 28;
  localparam int X_STEP   = 25600;            // reset x spacing, 100.0 in Q8
  localparam int QCLAMP_B = 25;               // corrections beyond this saturate

  localparam logic [LEN_W-1:0]   LINK_LENGTH_RST = 16'd12800;
  localparam logic [LEN_W-1:0]   GRAVITY_RST     = 16'd3072;
  localparam logic [COORD_W-1:0] FLOOR_RST       = 24'd2560;
  localparam logic [STIFF_W-1:0] STIFF_RST       = 9'd230;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 28'sd8388607;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -28'sd8388608;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } link_t;

  typedef struct packed {
    logic [LEN_W-1:0]   link_length;
    logic [LEN_W-1:0]   gravity_step;
    coord_t             floor_height;
    logic [STIFF_W-1:0] stiffness;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_LINK_LENGTH = 2'd0,
    REG_GRAVITY     = 2'd1,
    REG_FLOOR       = 2'd2,
    REG_STIFFNESS   = 2'd3
  } reg_idx_t;

  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    coord_t r;
    if (v > SUM_MAX) begin
      r = 24'sh7FFFFF;
    end else if (v < SUM_MIN) begin
      r = 24'sh800000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/rlcr_ifs.sv
// ----------------------------------------------------------------------------
// rlcr interfaces
// Valid/ready channels for anchor items and link position items.
// ----------------------------------------------------------------------------
interface rlcr_anchor_if import rlcr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t anchor_x;
  coord_t anchor_y;
  coord_t anchor_z;

  modport source(output valid, output anchor_x, output anchor_y, output anchor_z,
                 input ready);
  modport sink(input valid, input anchor_x, input anchor_y, input anchor_z,
               output ready);
endinterface

interface rlcr_link_if import rlcr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] link_index;
  coord_t           pos_x;
  coord_t           pos_y;
  coord_t           pos_z;
  logic             last_of_tick;

  modport source(output valid, output link_index, output pos_x, output pos_y,
                 output pos_z, output last_of_tick, input ready);
  modport sink(input valid, input link_index, input pos_x, input pos_y,
               input pos_z, input last_of_tick, output ready);
endinterface

FILE: src/rlcr_cfg.sv
// ----------------------------------------------------------------------------
// rlcr_cfg
// APB register file: link length, gravity step, floor height, stiffness.
// ----------------------------------------------------------------------------
module rlcr_cfg import rlcr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_t sel;

  assign sel    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_length  <= LINK_LENGTH_RST;
      cfg.gravity_step <= GRAVITY_RST;
      cfg.floor_height <= FLOOR_RST;
      cfg.stiffness    <= STIFF_RST;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        REG_LINK_LENGTH: cfg.link_length  <= pwdata[LEN_W-1:0];
        REG_GRAVITY:     cfg.gravity_step <= pwdata[LEN_W-1:0];
        REG_FLOOR:       cfg.floor_height <= pwdata[COORD_W-1:0];
        REG_STIFFNESS:   cfg.stiffness    <= pwdata[STIFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_LINK_LENGTH: prdata = {16'd0, cfg.link_length};
      REG_GRAVITY:     prdata = {16'd0, cfg.gravity_step};
      REG_FLOOR:       prdata = {{8{cfg.floor_height[COORD_W-1]}}, cfg.floor_height};
      REG_STIFFNESS:   prdata = {23'd0, cfg.stiffness};
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: src/rlcr_store.sv
// ----------------------------------------------------------------------------
// rlcr_store
// Link position memory, one read and one write port, registered read.
// Entries never written since reset read as the rest pose.
// ----------------------------------------------------------------------------
module rlcr_store import rlcr_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  link_t         wr_data,
  output link_t         rd_data
);

  localparam int PW = AW + 15;   // X_STEP fits in 15 bits

  link_t            mem [DEPTH];
  logic [DEPTH-1:0] written;
  link_t            rd_q;
  logic             rd_written;
  logic [AW-1:0]    rd_addr_q;
  logic [PW-1:0]    x_rest;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q       <= mem[rd_addr];
      rd_written <= written[rd_addr];
      rd_addr_q  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // rest pose x = 100.0 * index, never near saturation for 64 links
  assign x_rest = PW'(rd_addr_q) * PW'(X_STEP);

  always_comb begin
    if (rd_written) begin
      rd_data = rd_q;
    end else begin
      rd_data.x = coord_t'({{(COORD_W-PW){1'b0}}, x_rest});
      rd_data.y = '0;
      rd_data.z = '0;
    end
  end

endmodule

FILE: src/rlcr_sqrt.sv
// ----------------------------------------------------------------------------
// rlcr_sqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rlcr_sqrt import rlcr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [DIST_W-1:0] root
);

  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitm;
  logic [SQ_W-1:0] trial;
  logic            busy;

  assign trial = res + bitm;
  assign root  = res[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      res  <= '0;
      bitm <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && bitm[0];
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitm[0]) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: src/rlcr_div.sv
// ----------------------------------------------------------------------------
// rlcr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rlcr_div import rlcr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [CW-1:0]    cnt;
  logic             busy;

  assign trial = {rem, quo[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      if (trial >= {1'b0, den_q}) begin
        rem <= DEN_W'(trial - {1'b0, den_q});
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/rope_link_constraint_relaxer_unit.sv
// ----------------------------------------------------------------------------
// rope_link_constraint_relaxer_unit
// Rope tick: pin link 0, gravity and floor on the rest, one forward pass of
// distance constraints through the link memory, then stream out the links, at most MAX_EMIT (16).
// ----------------------------------------------------------------------------
// Work: each link after link 0 takes one square root and, unless its span is
//   zero, three divides, one per axis; emitted items wait on the sink.
// Throughput: one anchor item per tick; a new item is taken once the last
//   link item of the previous tick has gone.
// Reset: synchronous; registers take their reset values and the memory reads
//   as the rest pose until each entry is written; no clearing pass.
module rope_link_constraint_relaxer_unit import rlcr_pkg::*; #(
  parameter int LINK_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  rlcr_anchor_if.sink anchor_ch,
  rlcr_link_if.source link_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW     = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
  localparam int EMIT_N = (LINK_COUNT < MAX_EMIT) ? LINK_COUNT : MAX_EMIT;

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_RD      = 17'h00002,
    S_LOAD    = 17'h00004,
    S_DELTA   = 17'h00008,
    S_SQ      = 17'h00010,
    S_ROOT_GO = 17'h00020,
    S_ROOT    = 17'h00040,
    S_DIFF    = 17'h00080,
    S_MUL1    = 17'h00100,
    S_MUL2    = 17'h00200,
    S_RND     = 17'h00400,
    S_DIV_GO  = 17'h00800,
    S_DIV     = 17'h01000,
    S_WR      = 17'h02000,
    S_ERD     = 17'h04000,
    S_EWAIT   = 17'h08000,
    S_EOUT    = 17'h10000
  } state_t;

  state_t state;
  cfg_t   cfg;

  coord_t            cur    [3];
  coord_t            prev   [3];
  logic [MAG_W-1:0]  dmag   [3];
  logic              dneg   [3];
  logic [1:0]        axis;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     ecnt;
  logic [SQ_W-1:0]   sq_acc;
  logic [DIST_W-1:0] span;
  logic [DIST_W-1:0] diffmag;
  logic              diffneg;
  logic [PROD_W-1:0] prod;
  logic [SCL_W:0]    scaled;
  logic [NUM_W-1:0]  num;

  // memory ports
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  link_t         wr_data;
  link_t         rd_data;

  logic              accept;
  logic              sqrt_done;
  logic [DIST_W-1:0] root;
  logic              div_done;
  logic [NUM_W-1:0]  quo;

  // combinational helpers
  logic signed [SUM_W-1:0]  grav_s;
  logic signed [SUM_W-1:0]  y_drop;
  coord_t                   y_sat;
  logic signed [DIFF_W-1:0] diff_s;
  logic signed [SUM_W-1:0]  delta   [3];
  logic [DIST_W-1:0]        qc;
  logic signed [SUM_W-1:0]  corr;
  logic signed [SUM_W-1:0]  moved;
  logic [SCL_W-1:0]         scl_raw;

  assign accept          = anchor_ch.valid && anchor_ch.ready;
  assign anchor_ch.ready = (state == S_IDLE);

  rlcr_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  assign rd_en   = (state == S_RD) || (state == S_ERD);
  assign rd_addr = (state == S_ERD) ? ecnt : idx;
  assign wr_en   = accept || (state == S_WR);
  assign wr_addr = accept ? '0 : idx;

  always_comb begin
    if (accept) begin
      wr_data.x = anchor_ch.anchor_x;
      wr_data.y = anchor_ch.anchor_y;
      wr_data.z = anchor_ch.anchor_z;
    end else begin
      wr_data.x = cur[0];
      wr_data.y = cur[1];
      wr_data.z = cur[2];
    end
  end

  rlcr_store #(.DEPTH(LINK_COUNT), .AW(AW)) u_store (
    .clk, .rst, .rd_en, .rd_addr, .wr_en, .wr_addr, .wr_data, .rd_data
  );

  rlcr_sqrt u_sqrt (
    .clk, .rst, .start(state == S_ROOT_GO), .radicand(sq_acc),
    .done(sqrt_done), .root
  );

  rlcr_div u_div (
    .clk, .rst, .start(state == S_DIV_GO), .num, .den({span, 8'd0}),
    .done(div_done), .quo
  );

  // gravity then floor
  assign grav_s = $signed({{(SUM_W-LEN_W){1'b0}}, cfg.gravity_step});
  assign y_drop = SUM_W'(rd_data.y) - grav_s;
  assign y_sat  = sat_coord(y_drop);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      delta[a] = SUM_W'(cur[a]) - SUM_W'(prev[a]);
    end
  end

  assign diff_s = $signed({{(DIFF_W-LEN_W){1'b0}}, cfg.link_length})
                - $signed({1'b0, span});

  // corrections that large saturate the coordinate anyway
  assign qc      = (|quo[NUM_W-1:QCLAMP_B]) ? DIST_W'(1) << QCLAMP_B
                                              : {1'b0, quo[QCLAMP_B-1:0]};
  assign corr    = (diffneg != dneg[axis]) ? -$signed({2'b00, qc})
                                           : $signed({2'b00, qc});
  assign moved   = SUM_W'(cur[axis]) + corr;
  assign scl_raw = SCL_W'(prod) * SCL_W'(cfg.stiffness);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      link_ch.valid  <= 1'b0;
      idx            <= '0;
      ecnt           <= '0;
      axis           <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            prev[0] <= anchor_ch.anchor_x;
            prev[1] <= anchor_ch.anchor_y;
            prev[2] <= anchor_ch.anchor_z;
            idx     <= AW'(1);
            state   <= S_RD;
          end
        end
        S_RD: state <= S_LOAD;
        S_LOAD: begin
          cur[0] <= rd_data.x;
          cur[1] <= (y_sat < cfg.floor_height) ? cfg.floor_height : y_sat;
          cur[2] <= rd_data.z;
          state  <= S_DELTA;
        end
        S_DELTA: begin
          for (int a = 0; a < 3; a++) begin
            dneg[a] <= delta[a][SUM_W-1];
            dmag[a] <= delta[a][SUM_W-1] ? MAG_W'(-delta[a]) : MAG_W'(delta[a]);
          end
          sq_acc <= '0;
          axis   <= '0;
          state  <= S_SQ;
        end
        S_SQ: begin
          sq_acc <= sq_acc + SQ_W'(dmag[axis]) * SQ_W'(dmag[axis]);
          if (axis == 2'd2) begin
            state <= S_ROOT_GO;
          end else begin
            axis <= axis + 1'b1;
          end
        end
        S_ROOT_GO: state <= S_ROOT;
        S_ROOT: begin
          if (sqrt_done) begin
            span  <= root;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          diffneg <= diff_s[DIFF_W-1];
          diffmag <= diff_s[DIFF_W-1] ? DIST_W'(-diff_s) : DIST_W'(diff_s);
          axis    <= '0;
          state   <= (span == '0) ? S_WR : S_MUL1;
        end
        S_MUL1: begin
          prod  <= PROD_W'(diffmag) * PROD_W'(dmag[axis]);
          state <= S_MUL2;
        end
        S_MUL2: begin
          // first pair gets double gain
          scaled <= (idx == AW'(1)) ? {scl_raw, 1'b0} : {1'b0, scl_raw};
          state  <= S_RND;
        end
        S_RND: begin
          num   <= NUM_W'(scaled) + NUM_W'({span, 7'd0});
          state <= S_DIV_GO;
        end
        S_DIV_GO: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            cur[axis] <= sat_coord(moved);
            if (axis == 2'd2) begin
              state <= S_WR;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_MUL1;
            end
          end
        end
        S_WR: begin
          prev <= cur;
          if (idx == AW'(LINK_COUNT - 1)) begin
            ecnt  <= '0;
            state <= S_ERD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_ERD: state <= S_EWAIT;
        S_EWAIT: begin
          link_ch.link_index   <= IDX_W'(ecnt);
          link_ch.pos_x        <= rd_data.x;
          link_ch.pos_y        <= rd_data.y;
          link_ch.pos_z        <= rd_data.z;
          link_ch.last_of_tick <= (ecnt == AW'(EMIT_N - 1));
          link_ch.valid        <= 1'b1;
          state                <= S_EOUT;
        end
        S_EOUT: begin
          if (link_ch.ready) begin
            link_ch.valid <= 1'b0;
            if (ecnt == AW'(EMIT_N - 1)) begin
              state <= S_IDLE;
            end else begin
              ecnt  <= ecnt + 1'b1;
              state <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/rlcr_checker.sv
// ----------------------------------------------------------------------------
// rlcr_checker
// Port-level checks on the rope link relaxer, bound to the top level.
// ----------------------------------------------------------------------------
module rlcr_checker import rlcr_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] out_index,
  input coord_t           out_x,
  input logic             out_last
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_index))
    else $error("link item changed while stalled");

  // no new tick is taken while link items are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("anchor taken while link items pending");

  // one tick in flight: ready drops after an anchor item is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second anchor item taken during a tick");

  // the tick ends with its marked item
  a_tick_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("block not idle after last link item");

endmodule

bind rope_link_constraint_relaxer_unit rlcr_checker u_rlcr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (anchor_ch.valid),
  .in_ready  (anchor_ch.ready),
  .out_valid (link_ch.valid),
  .out_ready (link_ch.ready),
  .out_index (link_ch.link_index),
  .out_x     (link_ch.pos_x),
  .out_last  (link_ch.last_of_tick)
);
